### hw/rtl/anc_pkg.sv
// Package for the address negative cache: payload structs, command struct,
// controller state type and fixed field widths. No dependencies.
package anc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int TTL_BITS_DEF = 16;

    localparam int ADDR_W = 32;
    localparam int REQ_TTL_W = 16;
    localparam int CFG_W = 16;
    localparam int OCC_W = 5;

    localparam logic [CFG_W-1:0] DEFAULT_TTL_RESET = 16'd3;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_LOOKUP = 2'd1,
        K_TICK   = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ADDR_W-1:0]    ip_address;
        logic [REQ_TTL_W-1:0] ttl_seconds;
    } t_in_item;

    typedef struct packed {
        logic             present;
        logic             table_full;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_COUNT
    } t_state;

endpackage

### hw/rtl/anc_ctrl.sv
// Controller for the address negative cache: request sequencing and the
// output valid flag. Depends on anc_pkg.
module anc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output anc_pkg::t_cmd o_cmd
);
    import anc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_stall     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_COUNT;
            end
            S_COUNT: begin
                // The result register takes the new result once it is empty
                // or its current transfer completes this cycle.
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_out_valid;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && r_state == S_EXEC))
        else $error("accepted request did not start execution");

    a_exec_to_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_COUNT))
        else $error("execute step did not advance to count");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && r_state != S_COUNT) |=> !o_valid)
        else $error("result repeated after its transfer");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out) |-> (!o_valid || !i_stall))
        else $error("pending result overwritten");
`endif

endmodule

### hw/rtl/anc_datapath.sv
// Datapath for the address negative cache: entry lanes with parallel match,
// countdown, free slot selection, occupancy count and result register.
// Depends on anc_pkg.
module anc_datapath #(
    parameter int ENTRIES  = anc_pkg::ENTRIES_DEF,
    parameter int TTL_BITS = anc_pkg::TTL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  anc_pkg::t_cmd             i_cmd,
    input  anc_pkg::t_in_item         i_req,
    input  logic                      i_cfg_we,
    input  logic [anc_pkg::CFG_W-1:0] i_cfg_wdata,
    output anc_pkg::t_out_item        o_result
);
    import anc_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LW    = (TTL_BITS > REQ_TTL_W) ? TTL_BITS : REQ_TTL_W;
    localparam logic [LW-1:0] TTL_MAX = LW'((64'd1 << TTL_BITS) - 64'd1);

    t_in_item             r_req;
    logic [CFG_W-1:0]     r_default_ttl;
    logic [ENTRIES-1:0]   r_entry_valid;
    logic [ADDR_W-1:0]    r_entry_address [ENTRIES];
    logic [TTL_BITS-1:0]  r_entry_remaining [ENTRIES];
    logic                 r_present;
    logic                 r_full;
    t_out_item            r_out;

    logic [ENTRIES-1:0]   free_vec;
    logic [ENTRIES-1:0]   free_first;
    logic                 any_free;
    logic [ENTRIES-1:0]   match_vec;
    logic [REQ_TTL_W-1:0] life_raw;
    logic [LW-1:0]        life_ext;
    logic [TTL_BITS-1:0]  life;
    logic [CNT_W-1:0]     occ_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_ttl <= DEFAULT_TTL_RESET;
        end else if (i_cfg_we) begin
            r_default_ttl <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    // Lowest free slot as a one-hot mask: isolate the lowest set bit.
    assign free_vec   = ~r_entry_valid;
    assign free_first = free_vec & (~free_vec + ENTRIES'(1));
    assign any_free   = |free_vec;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = r_entry_valid[i] && (r_entry_address[i] == r_req.ip_address);
        end
    end

    // Effective lifetime: zero selects the default, zero is raised to one and
    // anything beyond the counter saturates.
    always_comb begin
        life_raw = (r_req.ttl_seconds == '0) ? r_default_ttl : r_req.ttl_seconds;
        if (life_raw == '0) begin
            life_raw = REQ_TTL_W'(1);
        end
        life_ext = LW'(life_raw);
        if (life_ext > TTL_MAX) begin
            life_ext = TTL_MAX;
        end
        life = TTL_BITS'(life_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_entry_remaining[i] <= '0;
            end
        end else if (i_cmd.execute) begin
            unique case (t_kind'(r_req.kind))
                K_ADD: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (free_first[i]) begin
                            r_entry_valid[i]     <= 1'b1;
                            r_entry_remaining[i] <= life;
                        end
                    end
                end
                K_TICK: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_entry_valid[i]) begin
                            if (r_entry_remaining[i] <= TTL_BITS'(1)) begin
                                r_entry_valid[i]     <= 1'b0;
                                r_entry_remaining[i] <= '0;
                            end else begin
                                r_entry_remaining[i] <= r_entry_remaining[i] - TTL_BITS'(1);
                            end
                        end
                    end
                end
                K_CLEAR: begin
                    r_entry_valid <= '0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        r_entry_remaining[i] <= '0;
                    end
                end
                K_LOOKUP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && t_kind'(r_req.kind) == K_ADD) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (free_first[i]) begin
                    r_entry_address[i] <= r_req.ip_address;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_present <= (t_kind'(r_req.kind) == K_LOOKUP) && (|match_vec);
            r_full    <= (t_kind'(r_req.kind) == K_ADD) && !any_free;
        end
    end

    always_comb begin
        occ_count = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            occ_count = occ_count + CNT_W'(r_entry_valid[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.present    <= r_present;
            r_out.table_full <= r_full;
            r_out.occupancy  <= OCC_W'(occ_count);
        end
    end

    assign o_result = r_out;

endmodule

### hw/rtl/address_negative_cache_ttl_unit.sv
// Top level of the address negative cache with per-entry expiry.
// Instantiates anc_ctrl and anc_datapath; depends on anc_pkg.
//
//   Port group        Direction  Handshake            Payload
//   request channel   in         i_valid / o_stall    i_data (t_in_item)
//   result channel    out        o_valid / i_stall    o_data (t_out_item)
//   config write      in         i_cfg_we             i_cfg_wdata
//
// A request is captured at its transfer, executed against all entry lanes in the
// next cycle, and its result, with the occupancy count, is loaded in the count step.
// The next request is taken in the following cycle; no new request is taken before
// the last one is loaded, and a stalled result holds the count step.
// Synchronous active-low reset empties the table and sets the default TTL to 3.
module address_negative_cache_ttl_unit #(
    parameter int ENTRIES  = anc_pkg::ENTRIES_DEF,
    parameter int TTL_BITS = anc_pkg::TTL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  anc_pkg::t_in_item         i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output anc_pkg::t_out_item        o_data,
    input  logic                      i_cfg_we,
    input  logic [anc_pkg::CFG_W-1:0] i_cfg_wdata
);
    import anc_pkg::*;

    t_cmd cmd;

    anc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    anc_datapath #(
        .ENTRIES  (ENTRIES),
        .TTL_BITS (TTL_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_data)
    );

endmodule

### bench/tb_top.sv
// Testbench for address_negative_cache_ttl_unit: a clocked driver and monitor, a
// transaction-level predictor of the expiring address table, and a queue of expected results.
// Depends on anc_pkg and the unit under test only.
`timescale 1ns / 1ps

module tb_top;
    import anc_pkg::*;

    localparam int SLOTS = ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic drv_valid = 1'b0;
    t_in_item drv_data = '0;
    logic rsp_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic o_stall;
    logic o_valid;
    t_out_item o_data;

    // Predictor state: a private copy of the table and the default lifetime.
    bit line_valid[SLOTS];
    logic [ADDR_W-1:0] line_addr[SLOTS];
    logic [TTL_BITS_DEF-1:0] line_left[SLOTS];
    logic [CFG_W-1:0] model_default_ttl;

    t_in_item pending_items[$];
    t_out_item expected_results[$];
    logic [ADDR_W-1:0] addr_pool[$];

    int cycle_count = 0;
    int error_count = 0;
    int requests_taken = 0;
    int lookup_hits = 0;
    int adds_dropped = 0;
    int expiries = 0;
    int settings_used = 1;
    bit req_taken = 1'b0;
    int burst_left = 4;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_timer = 0;

    address_negative_cache_ttl_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (drv_valid),
        .o_stall     (o_stall),
        .i_data      (drv_data),
        .o_valid     (o_valid),
        .i_stall     (rsp_stall),
        .o_data      (o_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Applies one operation to the predicted table and returns the result it produces.
    function automatic t_out_item cache_apply(t_in_item req);
        t_out_item res;
        int slot;
        int count;
        logic [TTL_BITS_DEF-1:0] life;
        res = '0;
        slot = -1;
        case (t_kind'(req.kind))
            K_ADD: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot < 0 && !line_valid[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    res.table_full = 1'b1;
                    adds_dropped++;
                end else begin
                    life = (req.ttl_seconds == '0) ? model_default_ttl : req.ttl_seconds;
                    if (life == '0) begin
                        life = TTL_BITS_DEF'(1);
                    end
                    line_valid[slot] = 1'b1;
                    line_addr[slot] = req.ip_address;
                    line_left[slot] = life;
                end
            end
            K_LOOKUP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (line_valid[i] && line_addr[i] == req.ip_address) begin
                        res.present = 1'b1;
                    end
                end
                if (res.present) begin
                    lookup_hits++;
                end
            end
            K_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (line_valid[i]) begin
                        if (line_left[i] <= 1) begin
                            line_left[i] = '0;
                            line_valid[i] = 1'b0;
                            expiries++;
                        end else begin
                            line_left[i] = line_left[i] - 1'b1;
                        end
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    line_valid[i] = 1'b0;
                    line_left[i] = '0;
                end
            end
        endcase
        count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (line_valid[i]) begin
                count++;
            end
        end
        res.occupancy = count[OCC_W-1:0];
        return res;
    endfunction

    // Request side: predict on every transfer. Result side: check against the oldest entry.
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && drv_valid && !o_stall) begin
            expected_results.push_back(cache_apply(drv_data));
            requests_taken++;
            req_taken = 1'b1;
        end
        if (i_rst_n && o_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: present=%0b full=%0b occ=%0d",
                         $time, o_data.present, o_data.table_full, o_data.occupancy);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_data.present !== want.present) begin
                    $display("%0t: present expected %0b actual %0b",
                             $time, want.present, o_data.present);
                    error_count++;
                end
                if (o_data.table_full !== want.table_full) begin
                    $display("%0t: table_full expected %0b actual %0b",
                             $time, want.table_full, o_data.table_full);
                    error_count++;
                end
                if (o_data.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, o_data.occupancy);
                    error_count++;
                end
            end
        end
    end

    // Driver: sends queued requests in bursts with random gaps between them.
    always @(negedge i_clk) begin
        logic next_valid;
        t_in_item next_data;
        next_valid = drv_valid;
        next_data = drv_data;
        if (i_rst_n && (!drv_valid || req_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                next_data = pending_items.pop_front();
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        req_taken = 1'b0;
        drv_valid <= next_valid;
        drv_data <= next_data;
    end

    // Receiver stall: the pattern is redrawn whenever its timer runs out, including stall-free spans.
    always @(negedge i_clk) begin
        logic s;
        if (stall_timer == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_timer = $urandom_range(30, 120);
        end else begin
            stall_timer--;
        end
        case (stall_mode)
            0: s = 1'b0;
            1: s = 1'($urandom_range(0, 1));
            2: s = (cycle_count % 5) < 2;
            default: s = ($urandom_range(0, 5) != 0);
        endcase
        rsp_stall <= s;
    end

    task automatic push_item(t_kind kind, logic [ADDR_W-1:0] addr,
                             logic [REQ_TTL_W-1:0] ttl);
        t_in_item item;
        item.kind = kind;
        item.ip_address = addr;
        item.ttl_seconds = ttl;
        pending_items.push_back(item);
    endtask

    // Random operation; lookups mostly hit recently added addresses so that hits are common.
    task automatic push_random(int add_pct, int tick_pct);
        int roll;
        int pick;
        logic [ADDR_W-1:0] addr;
        logic [REQ_TTL_W-1:0] ttl;
        roll = $urandom_range(0, 99);
        addr = $urandom();
        ttl = REQ_TTL_W'($urandom());
        if (roll < add_pct) begin
            if ($urandom_range(0, 9) < 3 && addr_pool.size() > 0) begin
                addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            end
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                ttl = '0;
            end else if (pick < 8) begin
                ttl = REQ_TTL_W'($urandom_range(1, 6));
            end else if (pick == 8) begin
                ttl = REQ_TTL_W'($urandom_range(7, 40));
            end
            addr_pool.push_back(addr);
            if (addr_pool.size() > 24) begin
                void'(addr_pool.pop_front());
            end
            push_item(K_ADD, addr, ttl);
        end else if (roll < add_pct + tick_pct) begin
            push_item(K_TICK, addr, ttl);
        end else if (roll < add_pct + tick_pct + 4) begin
            push_item(K_CLEAR, addr, ttl);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7 && addr_pool.size() > 0) begin
                addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
                if (pick == 6) begin
                    addr = addr ^ (32'h1 << $urandom_range(0, 31));
                end
            end
            push_item(K_LOOKUP, addr, ttl);
        end
    endtask

    // Waits until every request went out and every result came back.
    task automatic wait_drained();
        while (pending_items.size() > 0 || drv_valid || expected_results.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_default_ttl(logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        model_default_ttl = value;
        settings_used++;
    endtask

    initial begin
        logic [CFG_W-1:0] ttl_settings[6];
        for (int i = 0; i < SLOTS; i++) begin
            line_valid[i] = 1'b0;
            line_addr[i] = '0;
            line_left[i] = '0;
        end
        model_default_ttl = DEFAULT_TTL_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset default lifetime of three seconds.
        push_item(K_LOOKUP, 32'h0, 16'h0);
        push_item(K_ADD, 32'h0, 16'h0);
        push_item(K_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        push_item(K_ADD, 32'h0, 16'h1);
        push_item(K_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
        push_item(K_LOOKUP, 32'h1, 16'h0);
        push_item(K_TICK, 32'hFFFF_FFFF, 16'hFFFF);
        push_item(K_TICK, 32'h0, 16'h0);
        push_item(K_TICK, 32'h1234_5678, 16'h5A5A);
        push_item(K_LOOKUP, 32'h0, 16'h0);
        // Fill the table; one entry is still live, so the last of these adds has no free slot.
        for (int i = 0; i < SLOTS; i++) begin
            push_item(K_ADD, 32'hC0A8_0000 + i, 16'h2);
        end
        push_item(K_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
        push_item(K_LOOKUP, 32'hFFFF_FFFF, 16'h0);
        for (int i = 0; i < 40; i++) begin
            push_random(35, 25);
        end
        wait_drained();

        // A default of zero still gives a stored entry one second of life.
        ttl_settings[0] = 16'd0;
        ttl_settings[1] = 16'd1;
        ttl_settings[2] = 16'hFFFF;
        ttl_settings[3] = CFG_W'($urandom_range(2, 8));
        ttl_settings[4] = CFG_W'($urandom());
        ttl_settings[5] = 16'd2;
        for (int p = 0; p < 6; p++) begin
            set_default_ttl(ttl_settings[p]);
            if (p == 0) begin
                push_item(K_ADD, 32'hA5A5_A5A5, 16'h0);
                push_item(K_LOOKUP, 32'hA5A5_A5A5, 16'h0);
                push_item(K_TICK, 32'h0, 16'h0);
                push_item(K_LOOKUP, 32'hA5A5_A5A5, 16'h0);
            end
            // Even phases lean on adds so the table runs full; odd ones churn entries.
            for (int i = 0; i < 125; i++) begin
                if (p % 2 == 0) begin
                    push_random(55, 15);
                end else begin
                    push_random(30, 30);
                end
            end
            wait_drained();
        end

        $display("Covered %0d transfers under %0d default lifetimes (0, 1 and 65535 among them).",
                 requests_taken, settings_used);
        $display("Lookup hits %0d, adds dropped on a full table %0d, entries expired %0d.",
                 lookup_hits, adds_dropped, expiries);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/anc_pkg.sv
hw/rtl/anc_ctrl.sv
hw/rtl/anc_datapath.sv
hw/rtl/address_negative_cache_ttl_unit.sv
bench/tb_top.sv
